// File: rtl/ipv6e_pkg.sv
// ----------------------------------------------------------------------------
// ipv6e_pkg
// Types and constants shared by the ipv6 text expander modules.
// ----------------------------------------------------------------------------
package ipv6e_pkg;

	localparam int GROUPS = 8;
	localparam int DIGITS_PER_GROUP = 4;
	localparam int GROUP_W = $clog2(GROUPS);
	localparam int DIGIT_W = $clog2(DIGITS_PER_GROUP);
	// two banks of digit storage, one per buffered address
	localparam int STORE_AW = 1 + GROUP_W + DIGIT_W;
	localparam int STORE_DEPTH = 2 * GROUPS * DIGITS_PER_GROUP;

	localparam logic [3:0] GROUPS_N = 4'd8;
	localparam logic [2:0] DIGITS_N = 3'd4;
	localparam logic [2:0] LAST_DIGIT = 3'd3;
	localparam logic [2:0] COLON_POS = 3'd4;
	localparam logic [2:0] LAST_SLOT = 3'd7;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	typedef struct packed {
		logic [7:0] in_char;
		logic in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic out_last;
	} out_t;

	// one parsed address waiting to be expanded
	typedef struct packed {
		logic [GROUPS-1:0][2:0] glen;
		logic [3:0] gcount;
		logic gap_seen;
		logic [3:0] gap_pos;
		logic bank;
	} job_t;

	typedef struct packed {
		logic en;
		logic [STORE_AW-1:0] addr;
		logic [7:0] data;
	} wr_t;

endpackage

// File: rtl/ipv6e_front.sv
// ----------------------------------------------------------------------------
// ipv6e_front
// Parses compressed text: collects group lengths and the double colon, writes
// digits into the store and hands a job to the queue on the last character.
// ----------------------------------------------------------------------------
module ipv6e_front (
	input  logic clk,
	input  logic arst_n,
	input  ipv6e_pkg::in_t item,
	input  logic valid,
	output logic stall,
	input  logic full,
	output logic push,
	output ipv6e_pkg::job_t job,
	output ipv6e_pkg::wr_t wr
);
	import ipv6e_pkg::*;

	logic [GROUPS-1:0][2:0] glen_q, glen_a, glen_b;
	logic [3:0] gcount_q, gcount_a, gcount_b;
	logic [3:0] gap_pos_q, gap_pos_a;
	logic gap_seen_q, gap_seen_a;
	logic prev_colon_q, prev_colon_a;
	logic [2:0] cur_q, cur_a;
	logic bank_q;
	logic accept;

	assign stall = full;
	assign accept = valid && !full;

	always_comb begin
		glen_a = glen_q;
		gcount_a = gcount_q;
		gap_pos_a = gap_pos_q;
		gap_seen_a = gap_seen_q;
		prev_colon_a = prev_colon_q;
		cur_a = cur_q;
		wr.en = 1'b0;
		wr.addr = {bank_q, gcount_q[GROUP_W-1:0], cur_q[DIGIT_W-1:0]};
		wr.data = item.in_char;
		if (item.in_char == CHAR_COLON) begin
			if (prev_colon_q) begin
				if (!gap_seen_q) begin
					gap_seen_a = 1'b1;
					gap_pos_a = gcount_q;
				end
			end else begin
				if (cur_q != 3'd0 && gcount_q < GROUPS_N) begin
					glen_a[gcount_q[GROUP_W-1:0]] = cur_q;
					gcount_a = gcount_q + 4'd1;
				end
				cur_a = 3'd0;
			end
			prev_colon_a = 1'b1;
		end else begin
			if (cur_q < DIGITS_N) begin
				wr.en = accept && (gcount_q < GROUPS_N);
				cur_a = cur_q + 3'd1;
			end
			prev_colon_a = 1'b0;
		end

		// closing the open group at the end of the address
		glen_b = glen_a;
		gcount_b = gcount_a;
		if (cur_a != 3'd0 && gcount_a < GROUPS_N) begin
			glen_b[gcount_a[GROUP_W-1:0]] = cur_a;
			gcount_b = gcount_a + 4'd1;
		end

		job.glen = glen_b;
		job.gcount = gcount_b;
		job.gap_seen = gap_seen_a;
		job.gap_pos = gap_pos_a;
		job.bank = bank_q;
		push = accept && item.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glen_q <= '0;
			gcount_q <= '0;
			gap_pos_q <= '0;
			gap_seen_q <= 1'b0;
			prev_colon_q <= 1'b0;
			cur_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				glen_q <= '0;
				gcount_q <= '0;
				gap_pos_q <= '0;
				gap_seen_q <= 1'b0;
				prev_colon_q <= 1'b0;
				cur_q <= '0;
				bank_q <= !bank_q;
			end else begin
				glen_q <= glen_a;
				gcount_q <= gcount_a;
				gap_pos_q <= gap_pos_a;
				gap_seen_q <= gap_seen_a;
				prev_colon_q <= prev_colon_a;
				cur_q <= cur_a;
			end
		end
	end

endmodule

// File: rtl/ipv6e_queue.sv
// ----------------------------------------------------------------------------
// ipv6e_queue
// Two-entry job queue between the parser and the expander.
// ----------------------------------------------------------------------------
module ipv6e_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ipv6e_pkg::job_t push_job,
	input  logic pop,
	output logic full,
	output logic ready,
	output ipv6e_pkg::job_t head
);
	import ipv6e_pkg::*;

	job_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign ready = count_q != 2'd0;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/ipv6e_back.sv
// ----------------------------------------------------------------------------
// ipv6e_back
// Expands the head job into 39 characters: a slot/digit sequencer, the digit
// store read, and the output register.
// ----------------------------------------------------------------------------
module ipv6e_back (
	input  logic clk,
	input  logic arst_n,
	input  ipv6e_pkg::wr_t wr,
	input  logic ready,
	input  ipv6e_pkg::job_t job,
	output logic pop,
	output ipv6e_pkg::out_t item,
	output logic valid,
	input  logic stall
);
	import ipv6e_pkg::*;

	logic [7:0] store [STORE_DEPTH];

	logic [2:0] slot_q, pos_q;
	logic valid_s1, use_mem_s1, colon_s1, last_s1;
	logic [7:0] rdata_s1;
	logic out_valid_q;
	out_t out_q;

	logic out_free, s1_free, issue;
	logic [3:0] missing, slot4;
	logic [4:0] gap_end;
	logic src_ok;
	logic [3:0] src;
	logic [2:0] len;
	logic [3:0] lsum;
	logic hit, colon_step, last_step;
	logic [STORE_AW-1:0] raddr;

	assign out_free = !out_valid_q || !stall;
	assign s1_free = !valid_s1 || out_free;
	assign issue = ready && s1_free;

	always_comb begin
		missing = GROUPS_N - job.gcount;
		slot4 = {1'b0, slot_q};
		gap_end = {1'b0, job.gap_pos} + {1'b0, missing};
		src_ok = 1'b0;
		src = slot4;
		if (job.gap_seen) begin
			if (slot4 < job.gap_pos) begin
				src_ok = 1'b1;
			end else if ({1'b0, slot4} >= gap_end) begin
				src_ok = 1'b1;
				src = slot4 - missing;
			end
		end else begin
			src_ok = slot4 < job.gcount;
		end
		len = job.glen[src[GROUP_W-1:0]];
		// digit index within the stored group is pos - (4 - len)
		lsum = {1'b0, pos_q} + {1'b0, len};
		hit = src_ok && (lsum >= {1'b0, DIGITS_N});
		raddr = {job.bank, src[GROUP_W-1:0], lsum[DIGIT_W-1:0]};
		colon_step = pos_q == COLON_POS;
		last_step = (pos_q == LAST_DIGIT) && (slot_q == LAST_SLOT);
		pop = issue && last_step;
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store[wr.addr] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= store[raddr];
			use_mem_s1 <= hit && !colon_step;
			colon_s1 <= colon_step;
			last_s1 <= last_step;
		end
		if (valid_s1 && out_free) begin
			out_q.out_char <= use_mem_s1 ? rdata_s1 : (colon_s1 ? CHAR_COLON : CHAR_ZERO);
			out_q.out_last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pos_q <= '0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
				if (last_step) begin
					slot_q <= '0;
					pos_q <= '0;
				end else if (colon_step) begin
					slot_q <= slot_q + 3'd1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item = out_q;
	assign valid = out_valid_q;

endmodule

// File: rtl/ipv6_text_expander_top.sv
// ----------------------------------------------------------------------------
// ipv6_text_expander_top
// Expands compressed ipv6 address text into the full 39-character form.
// ----------------------------------------------------------------------------
// usage:
//   src channel: one character per item (src_item.in_char), in_last set on the
//   final character of an address. taken at an edge with src_valid high and
//   src_stall low. one item per cycle while the job queue has room.
//   dst channel: 39 items per address, eight four-digit groups joined by
//   colons, out_last set on the 39th. held stable while dst_stall is high.
//   output: after the edge that takes the last input character, the job passes
//   through the job queue, the digit store read and the output register; the burst
//   then runs one character per cycle unless dst_stall holds it.
//   the expander reads each character through the single read port of the digit
//   store; the parser takes one character a cycle while the job queue has room.
//   two parsed addresses can wait in the job queue; with both banks of the
//   digit store in use, src_stall rises until a burst has been issued.
//   reset: arst_n clears parser state, the job queue and the output stage;
//   the digit store needs no clearing.
// ----------------------------------------------------------------------------
module ipv6_text_expander_top (
	input  logic clk,
	input  logic arst_n,
	input  ipv6e_pkg::in_t src_item,
	input  logic src_valid,
	output logic src_stall,
	output ipv6e_pkg::out_t dst_item,
	output logic dst_valid,
	input  logic dst_stall
);
	import ipv6e_pkg::*;

	logic q_full, q_ready, q_push, q_pop;
	job_t push_job, head_job;
	wr_t store_wr;

	ipv6e_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(src_item),
		.valid(src_valid),
		.stall(src_stall),
		.full(q_full),
		.push(q_push),
		.job(push_job),
		.wr(store_wr)
	);

	ipv6e_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(push_job),
		.pop(q_pop),
		.full(q_full),
		.ready(q_ready),
		.head(head_job)
	);

	ipv6e_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(store_wr),
		.ready(q_ready),
		.job(head_job),
		.pop(q_pop),
		.item(dst_item),
		.valid(dst_valid),
		.stall(dst_stall)
	);

endmodule

// File: tb/ipv6_text_expander_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_text_expander_checker
// Watches both channels of the ipv6 text expander, keeps its own copy of the
// address parse state, works out the 39 expanded characters of every address
// and compares them in order with what the block sends out.
// ----------------------------------------------------------------------------
module ipv6_text_expander_checker (
	input  logic clk,
	input  logic arst_n,
	input  ipv6e_pkg::in_t src_item,
	input  logic src_valid,
	input  logic src_stall,
	input  ipv6e_pkg::out_t dst_item,
	input  logic dst_valid,
	input  logic dst_stall,
	output int errors,
	output int expected_left,
	output int checked,
	output int addresses
);
	import ipv6e_pkg::*;

	logic [7:0] digits [GROUPS * DIGITS_PER_GROUP];
	logic [2:0] glen [GROUPS];
	logic [3:0] ngroups;
	logic [3:0] gap_at;
	logic gap_seen;
	logic after_colon;
	logic [2:0] open_len;
	out_t expanded_chars [$];

	task automatic clear_address();
		foreach (glen[i]) glen[i] = '0;
		ngroups = '0;
		gap_at = '0;
		gap_seen = 1'b0;
		after_colon = 1'b0;
		open_len = '0;
	endtask

	task automatic close_group();
		if (open_len != 0 && ngroups < GROUPS_N) begin
			glen[ngroups[2:0]] = open_len;
			ngroups = ngroups + 4'd1;
		end
		open_len = '0;
	endtask

	task automatic push_char(input logic [7:0] c);
		out_t o;
		o.out_char = c;
		o.out_last = 1'b0;
		expanded_chars.insert(expanded_chars.size(), o);
	endtask

	// full form: eight groups, zero padded on the left, the gap filled with zero groups
	task automatic expand_address();
		int missing;
		int src;
		int len;
		int pad;
		out_t o;
		close_group();
		missing = GROUPS - int'(ngroups);
		for (int s = 0; s < GROUPS; s++) begin
			if (gap_seen) begin
				if (s < int'(gap_at))
					src = s;
				else if (s < int'(gap_at) + missing)
					src = -1;
				else
					src = s - missing;
			end else begin
				src = (s < int'(ngroups)) ? s : -1;
			end
			len = (src >= 0) ? int'(glen[src]) : 0;
			if (len > DIGITS_PER_GROUP)
				len = DIGITS_PER_GROUP;
			pad = DIGITS_PER_GROUP - len;
			for (int d = 0; d < DIGITS_PER_GROUP; d++) begin
				if (src >= 0 && d >= pad)
					push_char(digits[src * DIGITS_PER_GROUP + d - pad]);
				else
					push_char(CHAR_ZERO);
			end
			if (s < GROUPS - 1)
				push_char(CHAR_COLON);
		end
		o = expanded_chars.pop_back();
		o.out_last = 1'b1;
		expanded_chars.insert(expanded_chars.size(), o);
		clear_address();
		addresses++;
	endtask

	task automatic take_char(input in_t it);
		if (it.in_char == CHAR_COLON) begin
			if (after_colon) begin
				// only the first double colon marks the gap
				if (!gap_seen) begin
					gap_seen = 1'b1;
					gap_at = ngroups;
				end
			end else begin
				close_group();
			end
			after_colon = 1'b1;
		end else begin
			if (open_len < DIGITS_N) begin
				if (ngroups < GROUPS_N)
					digits[int'(ngroups) * DIGITS_PER_GROUP + int'(open_len)] = it.in_char;
				open_len = open_len + 3'd1;
			end
			after_colon = 1'b0;
		end
		if (it.in_last)
			expand_address();
	endtask

	task automatic check_char(input out_t got);
		out_t want;
		if (expanded_chars.size() == 0) begin
			errors++;
			$error("unexpected output item: out_char %h out_last %b",
				got.out_char, got.out_last);
		end else begin
			want = expanded_chars.pop_front();
			checked++;
			if (got.out_char !== want.out_char) begin
				errors++;
				$error("out_char: expected %h, actual %h", want.out_char, got.out_char);
			end
			if (got.out_last !== want.out_last) begin
				errors++;
				$error("out_last: expected %b, actual %b", want.out_last, got.out_last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_address();
			expanded_chars.delete();
		end else begin
			if (src_valid && !src_stall)
				take_char(src_item);
			if (dst_valid !== 1'b0 && !dst_stall)
				check_char(dst_item);
		end
		expected_left = expanded_chars.size();
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds compressed ipv6 address text into the expander: a few hand-picked
// corner addresses, then random well-formed, oversized and garbage text,
// with random idle bursts on both sides and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
	import ipv6e_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_CHARS = 300;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_t src_item = '0;
	logic src_valid = 1'b0;
	logic src_stall;
	out_t dst_item;
	logic dst_valid;
	logic dst_stall = 1'b0;

	int errors;
	int expected_left;
	int checked;
	int addresses;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit long_hold = 1'b0;
	in_t text [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ipv6_text_expander_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_item(src_item),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.dst_item(dst_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall)
	);

	ipv6_text_expander_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic add_char(input logic [7:0] c);
		in_t it;
		it.in_char = c;
		it.in_last = 1'b0;
		text.insert(text.size(), it);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic close_address();
		in_t it;
		it = text.pop_back();
		it.in_last = 1'b1;
		text.insert(text.size(), it);
	endtask

	function automatic logic [7:0] hex_digit();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'(CHAR_ZERO + v);
		else if ($urandom_range(0, 1) == 0)
			return 8'("a" + v - 10);
		else
			return 8'("A" + v - 10);
	endfunction

	// groups joined by colons, with one double colon whenever groups are missing and sometimes when none are
	task automatic make_address(input int max_groups, input int max_len);
		int n;
		int cut;
		bit gap;
		n = $urandom_range(0, max_groups);
		gap = (n < GROUPS) || ($urandom_range(0, 3) == 0);
		cut = $urandom_range(0, n);
		for (int g = 0; g < n; g++) begin
			if (gap && g == cut) begin
				add_char(CHAR_COLON);
				add_char(CHAR_COLON);
			end else if (g > 0) begin
				add_char(CHAR_COLON);
			end
			repeat ($urandom_range(1, max_len))
				add_char(hex_digit());
		end
		if (gap && cut == n) begin
			add_char(CHAR_COLON);
			add_char(CHAR_COLON);
		end
		close_address();
	endtask

	task automatic make_noise();
		int k;
		repeat ($urandom_range(1, 45)) begin
			k = $urandom_range(0, 9);
			if (k < 4)
				add_char(CHAR_COLON);
			else if (k < 8)
				add_char(hex_digit());
			else
				add_char(8'($urandom_range(0, 255)));
		end
		close_address();
	endtask

	// entered and left at a falling edge
	task automatic put_char(input in_t it);
		if (!calm && $urandom_range(0, 7) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		src_item <= it;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text();
		while (text.size() > 0)
			put_char(text.pop_front());
	endtask

	// receiver: random stall bursts, plus one long hold that backs up the input
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				dst_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				dst_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				dst_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				dst_stall <= 1'b0;
			end
		end
	end

	initial begin
		int first_random;
		int pick;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// leading double colon flagged on its colon
		add_text("::");
		close_address();
		// overlong group with extreme codes, then three colons in a row
		add_char(8'hFF);
		add_char(8'h00);
		add_text("abc:::f");
		close_address();
		// second double colon is ignored
		add_text("1::2::");
		close_address();
		// nine groups, the last one dropped
		add_text("9:8:7:6:5:4:3:2:1");
		close_address();
		// one group, no gap, zero groups appended
		add_text("7");
		close_address();
		send_text();

		first_random = sent;
		long_hold = 1'b1;
		while (sent < first_random + RANDOM_CHARS) begin
			if (sent >= first_random + RANDOM_CHARS * 4 / 5)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				make_address(GROUPS, DIGITS_PER_GROUP);
			else if (pick < 8)
				make_address(GROUPS + 2, DIGITS_PER_GROUP + 2);
			else
				make_noise();
			send_text();
		end
		src_valid <= 1'b0;

		wait (expected_left == 0);
		repeat (20) @(posedge clk);
		$display("%0d addresses from %0d input characters, %0d output characters checked",
			addresses, sent, checked);
		$display("corner addresses, oversized and garbage text, idle bursts and a %0d-cycle hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
